// File: src/salloc_pkg.sv
// Package for the slot allocator: sizes, codes and item types.
// Used by the top level; depends on nothing else.
package salloc_pkg;

   // Pool sizing. The stack depth follows from the pool size.
   localparam int MAX_SLOTS = 1024;
   localparam int STK_AW    = $clog2(MAX_SLOTS);
   localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1);

   // Field widths fixed by the item formats.
   localparam int IDX_W    = 10;
   localparam int ADDR_W   = 64;
   localparam int CAP_W    = 11;
   localparam int STRIDE_W = 9;
   localparam int PROD_W   = IDX_W + STRIDE_W;
   localparam int STAT_W   = 2;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 64;

   // Capacity limit: the pool size, or the number of indices a slot index holds.
   localparam int IDX_LIMIT = 1 << IDX_W;
   localparam int CAP_LIMIT = (MAX_SLOTS < IDX_LIMIT) ? MAX_SLOTS : IDX_LIMIT;

   // Request actions.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_SLOTS   = 2'd1;
   localparam logic [STAT_W-1:0] ST_STACK_FULL = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] CSR_SLOTS_IN_USE = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_BASE_ADDRESS = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_SLOT_STRIDE  = 2'd2;

   // Configuration reset values.
   localparam logic [CAP_W-1:0]    SLOTS_RESET  = 11'd1024;
   localparam logic [ADDR_W-1:0]   BASE_RESET   = '0;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd32;

   // Request item.
   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] free_slot;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [IDX_W-1:0]  slot_index;
      logic [ADDR_W-1:0] slot_address;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

// File: src/salloc_ram.sv
// Simple dual-port RAM for the free stack: one write port, one registered read port.
// Depends on nothing; sizes come from its parameters.
module salloc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a read at the address being written returns the old data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/slot_allocator_free_stack_unit.sv
// Slot allocator: LIFO free stack in front of a bump counter, with slot address output.
// Depends on salloc_pkg and salloc_ram.
// Items pass stage one and the result register; one item per cycle while rsp_ready is high.
// The stack top sits in a register and the entry under it is prefetched from the stack
// RAM read port, so back-to-back pops and pushes need no wait cycles.
// Reset clears the stack depth, the bump counter and all valid flags, and returns the
// configuration registers to their reset values; the stack RAM is not cleared, since
// only written entries are ever read.
module slot_allocator_free_stack_unit
   import salloc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   // Configuration registers.
   logic [CAP_W-1:0]    slots_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [STRIDE_W-1:0] stride_ff;

   // Stack and counter state.
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [IDX_W-1:0]   top_ff, top_in;
   logic [CAP_W-1:0]   fresh_ff, fresh_in;
   logic               byp_ff, byp_in;
   logic [IDX_W-1:0]   byp_data_ff;

   // Stage one and result registers.
   logic              s1_valid_ff;
   logic [IDX_W-1:0]  s1_idx_ff, s1_idx_in;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [STAT_W-1:0] s1_status_ff, s1_status_in;
   logic              s1_got_ff, s1_got_in;
   logic              out_valid_ff;
   rsp_type           out_ff;

   // RAM signals.
   logic               wr_en;
   logic [STK_AW-1:0]  wr_addr;
   logic [STK_AW-1:0]  rd_addr;
   logic [IDX_W-1:0]   rd_data;
   logic [IDX_W-1:0]   second;
   logic [DEPTH_W-1:0] rd_sum;
   logic [DEPTH_W-1:0] wr_sum;
   logic [CAP_W-1:0]   cap;
   logic               accept, out_load;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff  <= SLOTS_RESET;
         base_ff   <= BASE_RESET;
         stride_ff <= STRIDE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLOTS_IN_USE: slots_ff  <= csr_wdata[CAP_W-1:0];
            CSR_BASE_ADDRESS: base_ff   <= csr_wdata[ADDR_W-1:0];
            CSR_SLOT_STRIDE:  stride_ff <= csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // Usable capacity is the configured count saturated to the pool limit.
   assign cap = (slots_ff > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : slots_ff;

   // Pipeline handshake: the result register frees stage one, which frees the input.
   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign accept    = req_valid && req_ready;

   // The entry under the top comes from the RAM, or from the spill just written.
   assign second = byp_ff ? byp_data_ff : rd_data;

   // Allocate and free decisions against the stack top and bump counter.
   always_comb begin
      depth_in     = depth_ff;
      top_in       = top_ff;
      fresh_in     = fresh_ff;
      s1_idx_in    = '0;
      s1_status_in = ST_OK;
      s1_got_in    = 1'b0;
      wr_en        = 1'b0;
      byp_in       = 1'b0;
      if (accept) begin
         if (req_data.action == ACT_ALLOC) begin
            if (depth_ff != '0) begin
               s1_idx_in = top_ff;
               s1_got_in = 1'b1;
               top_in    = second;
               depth_in  = depth_ff - DEPTH_W'(1);
            end else if (fresh_ff < cap) begin
               s1_idx_in = fresh_ff[IDX_W-1:0];
               s1_got_in = 1'b1;
               fresh_in  = fresh_ff + CAP_W'(1);
            end else begin
               s1_status_in = ST_NO_SLOTS;
            end
         end else begin
            if (depth_ff < DEPTH_W'(MAX_SLOTS)) begin
               // The old top spills to the RAM below the new one.
               wr_en    = (depth_ff != '0);
               byp_in   = (depth_ff != '0);
               top_in   = req_data.free_slot;
               depth_in = depth_ff + DEPTH_W'(1);
            end else begin
               s1_status_in = ST_STACK_FULL;
            end
         end
      end
   end

   // RAM addressing: spill at depth minus one, prefetch at the next depth minus two.
   assign wr_sum  = depth_ff - DEPTH_W'(1);
   assign wr_addr = wr_sum[STK_AW-1:0];
   assign rd_sum  = depth_in - DEPTH_W'(2);
   assign rd_addr = rd_sum[STK_AW-1:0];

   salloc_ram #(
      .DEPTH (MAX_SLOTS),
      .WIDTH (IDX_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Stack state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         fresh_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         fresh_ff <= fresh_in;
         byp_ff   <= byp_in;
      end
   end

   // Stack top and spill bypass data.
   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      byp_data_ff <= top_ff;
   end

   // Stage one: chosen index, status and index times stride.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff    <= s1_idx_in;
         s1_status_ff <= s1_status_in;
         s1_got_ff    <= s1_got_in;
         s1_prod_ff   <= PROD_W'(s1_idx_in) * PROD_W'(stride_ff);
      end
   end

   // Result register: base plus product, wrapping at 64 bits; address zero when no slot was given.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff.slot_index   <= s1_idx_ff;
         out_ff.slot_address <= s1_got_ff ? (base_ff + ADDR_W'(s1_prod_ff)) : '0;
         out_ff.status       <= s1_status_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
